FILE: hdl/assert_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BMAM_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BMAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bmam_pkg.sv
// Types and constants of the banked memory address mapper.
package bmam_pkg;

   typedef enum logic [2:0] {
      REGION_ZERO_PAGE  = 3'd0,
      REGION_CACHE      = 3'd1,
      REGION_SYSTEM_RAM = 3'd2,
      REGION_USER_RAM   = 3'd3,
      REGION_PAGED      = 3'd4,
      REGION_DATA_ROM   = 3'd5,
      REGION_SYSTEM_ROM = 3'd6
   } region_type;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam int ZP_ADDR_W = 7;

   // bank register bytes inside the zero page
   localparam logic [ZP_ADDR_W-1:0] REG_CACHE_LO = 7'h70;
   localparam logic [ZP_ADDR_W-1:0] REG_CACHE_HI = 7'h71;
   localparam logic [ZP_ADDR_W-1:0] REG_DROM_LO  = 7'h72;
   localparam logic [ZP_ADDR_W-1:0] REG_DROM_HI  = 7'h73;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN0_LO  = 7'h74;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN0_HI  = 7'h75;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN1_LO  = 7'h78;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN1_HI  = 7'h79;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN2_LO  = 7'h7C;
   localparam logic [ZP_ADDR_W-1:0] REG_WIN2_HI  = 7'h7D;

   // bus page numbers (address bits 15:12)
   localparam logic [3:0] PAGE_LOW    = 4'h0;
   localparam logic [3:0] PAGE_USER   = 4'h1;
   localparam logic [3:0] PAGE_WIN0   = 4'h2;
   localparam logic [3:0] PAGE_DROM   = 4'hE;
   localparam logic [3:0] PAGE_SROM   = 4'hF;

   localparam logic [11:0] CACHE_START = 12'h080;
   localparam logic [11:0] SRAM_START  = 12'h100;

   localparam logic [1:0] WIN_0 = 2'd0;
   localparam logic [1:0] WIN_1 = 2'd1;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ZP_ADDR_W-1:0] index;
      logic [7:0]           wdata;
   } zp_access_type;

   typedef struct packed {
      logic [7:0]       cache_lo;
      logic [7:0]       cache_hi;
      logic [7:0]       drom_lo;
      logic [7:0]       drom_hi;
      logic [2:0][15:0] window_page;
   } bank_type;

endpackage

FILE: hdl/bmam_channel_if.sv
// Request and response channel interfaces of the mapper.
interface bmam_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] bus_address;
   logic [7:0]  write_data;

   modport source (output valid, output cmd, output bus_address, output write_data,
                   input ready);
   modport sink (input valid, input cmd, input bus_address, input write_data,
                 output ready);
endinterface

interface bmam_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  region;
   logic [29:0] physical_offset;
   logic        is_write;
   logic [7:0]  store_data;
   logic [7:0]  read_data;

   modport source (output valid, output region, output physical_offset,
                   output is_write, output store_data, output read_data,
                   input ready);
   modport sink (input valid, input region, input physical_offset,
                 input is_write, input store_data, input read_data,
                 output ready);
endinterface

FILE: hdl/bmam_zero_page.sv
// Zero page storage with bank register shadows.
`include "assert_macros.svh"

module bmam_zero_page #(
   parameter int ZERO_PAGE_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bmam_pkg::zp_access_type access,
   output bmam_pkg::bank_type     bank,
   output logic [7:0]             rdata
);

   localparam int AW = $clog2(ZERO_PAGE_DEPTH);

   logic [7:0]                 zp_mem_ff [ZERO_PAGE_DEPTH];
   logic [ZERO_PAGE_DEPTH-1:0] valid_ff;
   logic [7:0]                 rdata_ff;
   logic                       rvalid_ff;
   bmam_pkg::bank_type         bank_ff;
   logic [AW-1:0]              idx;

   assign idx = access.index[AW-1:0];

   // storage array, one write and one registered read
   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         zp_mem_ff[idx] <= access.wdata;
      end
      if (access.rd_en) begin
         rdata_ff <= zp_mem_ff[idx];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (access.wr_en) begin
            valid_ff[idx] <= 1'b1;
         end
         if (access.rd_en) begin
            rvalid_ff <= valid_ff[idx];
         end
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : 8'h00;

   // shadow copies of the bank register bytes for the address decode
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0;
      end else if (access.wr_en) begin
         case (access.index)
            bmam_pkg::REG_CACHE_LO: bank_ff.cache_lo             <= access.wdata;
            bmam_pkg::REG_CACHE_HI: bank_ff.cache_hi             <= access.wdata;
            bmam_pkg::REG_DROM_LO:  bank_ff.drom_lo              <= access.wdata;
            bmam_pkg::REG_DROM_HI:  bank_ff.drom_hi              <= access.wdata;
            bmam_pkg::REG_WIN0_LO:  bank_ff.window_page[0][7:0]  <= access.wdata;
            bmam_pkg::REG_WIN0_HI:  bank_ff.window_page[0][15:8] <= access.wdata;
            bmam_pkg::REG_WIN1_LO:  bank_ff.window_page[1][7:0]  <= access.wdata;
            bmam_pkg::REG_WIN1_HI:  bank_ff.window_page[1][15:8] <= access.wdata;
            bmam_pkg::REG_WIN2_LO:  bank_ff.window_page[2][7:0]  <= access.wdata;
            bmam_pkg::REG_WIN2_HI:  bank_ff.window_page[2][15:8] <= access.wdata;
            default: bank_ff <= bank_ff;
         endcase
      end
   end

   assign bank = bank_ff;

   `BMAM_ASSERT_NEXT(a_cache_lo_shadow, clock, reset, access.wr_en && access.index == bmam_pkg::REG_CACHE_LO, bank_ff.cache_lo == $past(access.wdata), "cache bank shadow missed a write")
   `BMAM_ASSERT_NEXT(a_drom_lo_shadow, clock, reset, access.wr_en && access.index == bmam_pkg::REG_DROM_LO, bank_ff.drom_lo == $past(access.wdata), "data rom shadow missed a write")
   `BMAM_ASSERT_NEXT(a_win2_hi_shadow, clock, reset, access.wr_en && access.index == bmam_pkg::REG_WIN2_HI, bank_ff.window_page[2][15:8] == $past(access.wdata), "window 2 shadow missed a write")

endmodule

FILE: hdl/banked_memory_address_mapper_core.sv
// The response item is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while the response side is ready; the response register frees as it drains.
// Reset (synchronous, active high) empties the response register and reads
// every zero page byte, bank registers included, as zero until written.
// Bank register writes steer the decode of the very next item.
`include "assert_macros.svh"

module banked_memory_address_mapper_core #(
   parameter int ZERO_PAGE_DEPTH = 128
) (
   input logic        clock,
   input logic        reset,
   bmam_req_if.sink   req_chan,
   bmam_rsp_if.source rsp_chan
);

   logic                    req_accept;
   logic [3:0]              page;
   logic [11:0]             low;
   logic [3:0]              rel_page;
   logic [15:0]             win_page;
   logic                    is_zp;
   bmam_pkg::zp_access_type zp_access;
   bmam_pkg::bank_type      bank;
   logic [7:0]              zp_rdata;

   bmam_pkg::region_type    region_in;
   logic [29:0]             offset_in;

   logic                    rsp_valid_ff;
   bmam_pkg::region_type    region_ff;
   logic [29:0]             offset_ff;
   logic                    is_write_ff;
   logic [7:0]              store_data_ff;
   logic                    zp_read_ff;

   // Take a new item whenever the response register is empty or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign page     = req_chan.bus_address[15:12];
   assign low      = req_chan.bus_address[11:0];
   assign rel_page = page - bmam_pkg::PAGE_WIN0;
   assign is_zp    = (page == bmam_pkg::PAGE_LOW) && (low < bmam_pkg::CACHE_START);

   // Zero page access: store on write, fetch on read; only for accepted items.
   always_comb begin
      zp_access.wr_en = req_accept && is_zp && (req_chan.cmd == bmam_pkg::CMD_WRITE);
      zp_access.rd_en = req_accept && is_zp && (req_chan.cmd == bmam_pkg::CMD_READ);
      zp_access.index = req_chan.bus_address[bmam_pkg::ZP_ADDR_W-1:0];
      zp_access.wdata = req_chan.write_data;
   end

   bmam_zero_page #(
      .ZERO_PAGE_DEPTH(ZERO_PAGE_DEPTH)
   ) u_zero_page (
      .clock (clock),
      .reset (reset),
      .access(zp_access),
      .bank  (bank),
      .rdata (zp_rdata)
   );

   // Pick the page number register of the window: four bus pages per window.
   always_comb begin
      case (rel_page[3:2])
         bmam_pkg::WIN_0: win_page = bank.window_page[0];
         bmam_pkg::WIN_1: win_page = bank.window_page[1];
         default:         win_page = bank.window_page[2];
      endcase
   end

   // Address decode: region and byte offset inside it.
   always_comb begin
      region_in = bmam_pkg::REGION_PAGED;
      offset_in = {win_page, rel_page[1:0], low};
      case (page)
         bmam_pkg::PAGE_LOW: begin
            if (low < bmam_pkg::CACHE_START) begin
               region_in = bmam_pkg::REGION_ZERO_PAGE;
               offset_in = {18'd0, low};
            end else if (low < bmam_pkg::SRAM_START) begin
               // cache line: low seven bits, then the two cache bank bytes
               region_in = bmam_pkg::REGION_CACHE;
               offset_in = {7'd0, bank.cache_hi, bank.cache_lo, low[6:0]};
            end else begin
               region_in = bmam_pkg::REGION_SYSTEM_RAM;
               offset_in = {18'd0, low - bmam_pkg::SRAM_START};
            end
         end
         bmam_pkg::PAGE_USER: begin
            region_in = bmam_pkg::REGION_USER_RAM;
            offset_in = {18'd0, low};
         end
         bmam_pkg::PAGE_DROM: begin
            region_in = bmam_pkg::REGION_DATA_ROM;
            offset_in = {2'd0, bank.drom_hi, bank.drom_lo, low};
         end
         bmam_pkg::PAGE_SROM: begin
            region_in = bmam_pkg::REGION_SYSTEM_ROM;
            offset_in = {18'd0, low};
         end
         default: begin
            // paged windows keep the defaults above
            region_in = bmam_pkg::REGION_PAGED;
            offset_in = {win_page, rel_page[1:0], low};
         end
      endcase
   end

   // Response valid: set on accept, drop once taken with nothing new behind.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= req_chan.valid;
      end
   end

   // Response payload: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         region_ff     <= region_in;
         offset_ff     <= offset_in;
         is_write_ff   <= !is_zp && (req_chan.cmd == bmam_pkg::CMD_WRITE);
         store_data_ff <= (!is_zp && (req_chan.cmd == bmam_pkg::CMD_WRITE)) ?
                          req_chan.write_data : 8'h00;
         zp_read_ff    <= is_zp && (req_chan.cmd == bmam_pkg::CMD_READ);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.region          = region_ff;
   assign rsp_chan.physical_offset = offset_ff;
   assign rsp_chan.is_write        = is_write_ff;
   assign rsp_chan.store_data      = store_data_ff;
   assign rsp_chan.read_data       = zp_read_ff ? zp_rdata : 8'h00;

   `BMAM_ASSERT(a_write_not_internal, clock, reset, rsp_valid_ff && is_write_ff, region_ff != bmam_pkg::REGION_ZERO_PAGE, "external write tagged as zero page")
   `BMAM_ASSERT(a_read_data_zp_only, clock, reset, rsp_valid_ff && rsp_chan.read_data != 8'h00, region_ff == bmam_pkg::REGION_ZERO_PAGE && !is_write_ff, "read data outside a zero page read")
   `BMAM_ASSERT(a_store_needs_write, clock, reset, rsp_valid_ff && store_data_ff != 8'h00, is_write_ff, "store data without a write")
   `BMAM_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff, "accepted item produced no response")

endmodule
